FILE: src/ifp_pkg.sv
// Package with constants and types shared by the inertial sensor frame parser.
package ifp_pkg;

   // Frame header pair that opens every frame.
   localparam logic [7:0] HDR_FIRST  = 8'h3A;
   localparam logic [7:0] HDR_SECOND = 8'h0B;

   // Frame position codes. Any value below POS_AFTER_HDR or above POS_LAST means hunting.
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_HUNT          = 5'd0;
   localparam logic [POS_W-1:0] POS_AFTER_HDR     = 5'd2;
   localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = 5'd4;
   localparam logic [POS_W-1:0] POS_PAYLOAD_LAST  = 5'd13;
   localparam logic [POS_W-1:0] POS_CHECK         = 5'd14;
   localparam logic [POS_W-1:0] POS_LAST          = 5'd16;

   // Payload store geometry.
   localparam int PAYLOAD_BYTES = 10;
   localparam int PAYLOAD_IDX_W = 4;

   // Result field widths and the packed result word.
   localparam int ANGLE_W    = 17;
   localparam int WORD_W     = 16;
   localparam int RSP_BITS   = ANGLE_W + 4 * WORD_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Control from the frame tracker to the datapath for one byte.
   typedef struct packed {
      logic                     store_en;
      logic [PAYLOAD_IDX_W-1:0] store_idx;
      logic                     frame_good;
   } ifp_ctrl_type;

endpackage

FILE: src/imu_frame_parser_unit.sv
// Top level of the inertial sensor frame parser.
//
// The request channel carries one received serial byte per request. The
// block slides over the stream looking for the header 0x3A 0x0B, collects a
// 17-byte frame, checks the 8-bit additive sum of bytes 1 to 13 against
// byte 14, and on a match issues one response as the last frame byte is
// processed. A frame with a bad sum issues nothing. The response carries the
// heading relative to the first good frame's heading, the turn rate and the
// three accelerations, all in raw sensor counts.
// The request of the last frame byte is taken into the input register, and
// its response is registered in the response register before it shows on
// the rsp_ channel. Throughput is one request per cycle while no response
// waits untaken at the receiver; a response register parts the two sides,
// and the per-byte work is one counter step, one 8-bit add and one 17-bit
// subtract.
// Reset clears the valid bits of the input and response registers, the frame
// tracker (back to header search) and the angle reference. When the receiver
// stalls, the pending response holds, one more request waits in the input
// register, and req_tready then drops until the response is taken.
module imu_frame_parser_unit
   import ifp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [16:0] angle_relative, [32:17] turn_rate, [48:33] accel_x,
   // [64:49] accel_y, [80:65] accel_z, [87:81] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  byte_vld_ff, byte_vld_in;
   logic [7:0]            byte_ff;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [7:0]            payload_ff [PAYLOAD_BYTES];
   logic [WORD_W-1:0]     ref_ff;
   logic                  ref_taken_ff;
   logic                  advance;
   logic                  byte_fire;
   logic                  req_fire;
   ifp_ctrl_type          ctrl;
   logic [WORD_W-1:0]     word0, word1, word2, word3, word4;
   logic [WORD_W-1:0]     ref_eff;
   logic [ANGLE_W-1:0]    angle_rel;

   // Handshake: the input register moves on whenever the response slot is free.
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign byte_fire  = byte_vld_ff && advance;
   assign req_tready = !byte_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Input register valid.
   always_comb begin
      byte_vld_in = byte_vld_ff;
      if (req_fire) begin
         byte_vld_in = 1'b1;
      end else if (advance) begin
         byte_vld_in = 1'b0;
      end
   end

   // Response register valid.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (byte_fire) begin
         rsp_vld_in = ctrl.frame_good;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   ifp_frame_ctrl u_frame_ctrl (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .byte_data (byte_ff),
      .ctrl      (ctrl)
   );

   // Little-endian words from the payload store.
   assign word0 = {payload_ff[1], payload_ff[0]};
   assign word1 = {payload_ff[3], payload_ff[2]};
   assign word2 = {payload_ff[5], payload_ff[4]};
   assign word3 = {payload_ff[7], payload_ff[6]};
   assign word4 = {payload_ff[9], payload_ff[8]};

   // The first good frame becomes its own reference.
   assign ref_eff   = ref_taken_ff ? ref_ff : word0;
   assign angle_rel = {word0[WORD_W-1], word0} - {ref_eff[WORD_W-1], ref_eff};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         ref_taken_ff <= 1'b0;
         ref_ff       <= '0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (ctrl.frame_good && !ref_taken_ff) begin
            ref_taken_ff <= 1'b1;
            ref_ff       <= word0;
         end
      end
   end

   // Payload registers: input byte, payload store and response word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_tdata;
      end
      if (ctrl.store_en) begin
         payload_ff[ctrl.store_idx] <= byte_ff;
      end
      if (ctrl.frame_good) begin
         rsp_data_ff <= {{(RSP_DATA_W - RSP_BITS){1'b0}},
                         word4, word3, word2, word1, angle_rel};
      end
   end

   // A good frame always yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_good |=> rsp_vld_ff)
      else $error("good frame lost its response");

   // Once taken, the angle reference never changes.
   assert property (@(posedge clock) disable iff (reset)
      ref_taken_ff |=> (ref_taken_ff && $stable(ref_ff)))
      else $error("angle reference changed after capture");

   // The first good frame reports a zero relative angle.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.frame_good && !ref_taken_ff) |=> (rsp_data_ff[ANGLE_W-1:0] == '0))
      else $error("first frame angle not zero");

endmodule

FILE: src/ifp_frame_ctrl.sv
// Frame tracker: header search, frame position counter and running checksum.
module ifp_frame_ctrl
   import ifp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_fire,
   input  logic [7:0]   byte_data,
   output ifp_ctrl_type ctrl
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       sum_ff, sum_in;
   logic             hunting;
   logic [POS_W-1:0] store_off;

   // Positions outside the frame range behave as hunting.
   assign hunting   = (pos_ff < POS_AFTER_HDR) || (pos_ff > POS_LAST);
   assign store_off = pos_ff - POS_PAYLOAD_FIRST;

   // Next state for position, previous byte and checksum.
   always_comb begin
      pos_in  = pos_ff;
      prev_in = prev_ff;
      sum_in  = sum_ff;
      if (byte_fire) begin
         prev_in = byte_data;
         if (hunting) begin
            if (prev_ff == HDR_FIRST && byte_data == HDR_SECOND) begin
               pos_in = POS_AFTER_HDR;
               sum_in = HDR_SECOND;
            end else begin
               pos_in = POS_HUNT;
            end
         end else begin
            if (pos_ff <= POS_PAYLOAD_LAST) begin
               sum_in = sum_ff + byte_data;
            end else if (pos_ff == POS_CHECK) begin
               sum_in = sum_ff - byte_data;
            end
            if (pos_ff == POS_LAST) begin
               pos_in = POS_HUNT;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
      end
   end

   // Control outputs for the payload capture and the result.
   always_comb begin
      ctrl.store_en   = byte_fire && !hunting &&
                        (pos_ff >= POS_PAYLOAD_FIRST) && (pos_ff <= POS_PAYLOAD_LAST);
      ctrl.store_idx  = store_off[PAYLOAD_IDX_W-1:0];
      ctrl.frame_good = byte_fire && (pos_ff == POS_LAST) && (sum_ff == 8'd0);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         prev_ff <= 8'd0;
         sum_ff  <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         sum_ff  <= sum_in;
      end
   end

   // A good frame ends on its last byte, never while payload is captured.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_good |-> !ctrl.store_en)
      else $error("frame result and payload capture in the same cycle");

   // The last byte of a frame always returns the tracker to hunting.
   assert property (@(posedge clock) disable iff (reset)
      (byte_fire && pos_ff == POS_LAST) |=> (pos_ff == POS_HUNT))
      else $error("frame did not end after its last byte");

   // Payload indexes stay inside the store.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.store_en |-> (ctrl.store_idx < PAYLOAD_IDX_W'(PAYLOAD_BYTES)))
      else $error("payload index out of range");

endmodule

FILE: tb/sv/imu_frame_parser_unit_test.sv
// Self-checking testbench for the inertial sensor frame parser top level.
`timescale 1ns / 100ps

module imu_frame_parser_unit_test
   import ifp_pkg::*;
();

   // Number of random-part bytes to send after the directed frames.
   localparam int RANDOM_BYTES = 650;
   localparam int FRAME_BYTES  = 17;

   // One expected sensor reading, field by field.
   typedef struct {
      logic [ANGLE_W-1:0] angle;
      logic [WORD_W-1:0]  rate;
      logic [WORD_W-1:0]  acc_x;
      logic [WORD_W-1:0]  acc_y;
      logic [WORD_W-1:0]  acc_z;
   } reading_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [16:0] angle_relative, [32:17] turn_rate, [48:33] accel_x,
   // [64:49] accel_y, [80:65] accel_z, [87:81] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Parser state mirrored by the testbench.
   logic [POS_W-1:0] track_pos;
   logic [7:0]       last_byte;
   logic [7:0]       frame_sum;
   logic [7:0]       payload [PAYLOAD_BYTES];
   logic [15:0]      heading_ref;
   logic             heading_ref_valid;

   reading_type pending_readings[$];

   // Frame under construction and its five payload words.
   logic [7:0]  frame_buf [FRAME_BYTES];
   logic [15:0] frame_words [5];

   // Idling controls for the sender and the receiver process.
   bit req_idle;
   bit rsp_idle;
   int rsp_hold_cycles;

   int error_count;
   int bytes_sent;
   int frames_sent;
   int corrupt_frames;
   int readings_checked;

   imu_frame_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock, 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   // Advance the mirrored parser by one received byte and queue any reading.
   task automatic parse_byte(input logic [7:0] b);
      reading_type r;
      logic [15:0] w0;
      if (track_pos < POS_AFTER_HDR || track_pos > POS_LAST) begin
         if (last_byte == HDR_FIRST && b == HDR_SECOND) begin
            track_pos = POS_AFTER_HDR;
            frame_sum = HDR_SECOND;
         end else begin
            track_pos = POS_HUNT;
         end
      end else begin
         if (track_pos <= POS_PAYLOAD_LAST)
            frame_sum = frame_sum + b;
         if (track_pos >= POS_PAYLOAD_FIRST && track_pos <= POS_PAYLOAD_LAST)
            payload[track_pos - POS_PAYLOAD_FIRST] = b;
         if (track_pos == POS_CHECK)
            frame_sum = frame_sum - b;
         if (track_pos == POS_LAST) begin
            if (frame_sum == 8'd0) begin
               w0 = {payload[1], payload[0]};
               if (!heading_ref_valid) begin
                  heading_ref = w0;
                  heading_ref_valid = 1'b1;
               end
               r.angle = {w0[15], w0} - {heading_ref[15], heading_ref};
               r.rate  = {payload[3], payload[2]};
               r.acc_x = {payload[5], payload[4]};
               r.acc_y = {payload[7], payload[6]};
               r.acc_z = {payload[9], payload[8]};
               pending_readings.push_back(r);
            end
            track_pos = POS_HUNT;
         end else begin
            track_pos = track_pos + 1'b1;
         end
      end
      last_byte = b;
   endtask

   // Offer one byte, after a random gap when req_idle is set, and wait until the block takes it.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_idle ? $urandom_range(0, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      parse_byte(b);
      bytes_sent++;
   endtask

   // Send bytes first_idx through last_idx of the frame buffer.
   task automatic send_frame(input int first_idx, input int last_idx);
      for (int i = first_idx; i <= last_idx; i++)
         send_byte(frame_buf[i]);
   endtask

   // Stop offering and wait until every expected reading has come back.
   task automatic drain_readings();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() > 0) @(posedge clock);
   endtask

   // Extremes show up often; otherwise the word is uniform.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Build a full frame around frame_words; a corrupt frame gets a wrong sum.
   task automatic fill_frame(input bit corrupt);
      logic [7:0] sum;
      frame_buf[0] = HDR_FIRST;
      frame_buf[1] = HDR_SECOND;
      frame_buf[2] = 8'($urandom);
      frame_buf[3] = 8'($urandom);
      for (int k = 0; k < 5; k++) begin
         frame_buf[4 + 2 * k] = frame_words[k][7:0];
         frame_buf[5 + 2 * k] = frame_words[k][15:8];
      end
      sum = 8'd0;
      for (int i = 1; i <= 13; i++)
         sum = sum + frame_buf[i];
      frame_buf[14] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
      frame_buf[15] = 8'($urandom);
      frame_buf[16] = 8'($urandom);
      frames_sent++;
      if (corrupt)
         corrupt_frames++;
   endtask

   task automatic random_words();
      for (int k = 0; k < 5; k++)
         frame_words[k] = pick_word();
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endtask

   // Compare each accepted response with the oldest expected reading.
   always @(posedge clock) begin
      reading_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("response with no reading expected: %h", rsp_tdata);
            error_count++;
         end else begin
            r = pending_readings.pop_front();
            check_field("angle_relative", $signed(r.angle), $signed(rsp_tdata[16:0]));
            check_field("turn_rate", $signed(r.rate), $signed(rsp_tdata[32:17]));
            check_field("accel_x", $signed(r.acc_x), $signed(rsp_tdata[48:33]));
            check_field("accel_y", $signed(r.acc_y), $signed(rsp_tdata[64:49]));
            check_field("accel_z", $signed(r.acc_z), $signed(rsp_tdata[80:65]));
            readings_checked++;
         end
      end
   end

   // Receiver: a random stall before each response when rsp_idle is set, or a long requested hold.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_idle ? $urandom_range(0, 14) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // The first good frame sets the heading reference, so its angle reads zero.
   task automatic test_first_frame();
      frame_words = '{16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
      fill_frame(1'b0);
      send_frame(0, 16);
      drain_readings();
   endtask

   // Opposite extremes, giving the largest positive relative heading.
   task automatic test_field_extremes();
      frame_words = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      fill_frame(1'b0);
      frame_buf[2] = 8'hFF;
      frame_buf[3] = 8'h00;
      frame_buf[14] = 8'd0;
      for (int i = 1; i <= 13; i++)
         frame_buf[14] = frame_buf[14] + frame_buf[i];
      send_frame(0, 16);
      drain_readings();
   endtask

   // A wrong checksum drops the frame, and the next good one still gets through.
   task automatic test_bad_checksum();
      random_words();
      fill_frame(1'b1);
      send_frame(0, 16);
      random_words();
      fill_frame(1'b0);
      send_frame(0, 16);
      drain_readings();
   endtask

   // A header pair inside the payload is plain data, not a new frame.
   task automatic test_header_in_frame();
      frame_words = '{16'h0B3A, 16'h3A0B, 16'h0B3A, 16'h1234, 16'h0B3A};
      fill_frame(1'b0);
      send_frame(0, 16);
      drain_readings();
   endtask

   // The last byte of one frame serves as the first header byte of the next.
   task automatic test_header_after_frame();
      random_words();
      fill_frame(1'b0);
      frame_buf[16] = HDR_FIRST;
      send_frame(0, 16);
      random_words();
      fill_frame(1'b0);
      send_frame(1, 16);
      drain_readings();
   endtask

   // Long receiver hold while frames arrive back to back, so the input stalls.
   task automatic test_backpressure();
      req_idle = 1'b0;
      rsp_hold_cycles = 150;
      for (int n = 0; n < 4; n++) begin
         random_words();
         fill_frame(1'b0);
         send_frame(0, 16);
      end
      drain_readings();
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames.
   task automatic test_random_stream();
      int start_bytes;
      int len;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         if ($urandom_range(0, 5) == 0)
            req_idle = !req_idle;
         if ($urandom_range(0, 5) == 0)
            rsp_idle = !rsp_idle;
         case ($urandom_range(0, 19))
            14, 15, 16: begin
               random_words();
               fill_frame(1'b1);
               send_frame(0, 16);
            end
            17: begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++) begin
                  case ($urandom_range(0, 3))
                     0: send_byte(HDR_FIRST);
                     1: send_byte(HDR_SECOND);
                     default: send_byte(8'($urandom));
                  endcase
               end
            end
            18: begin
               random_words();
               fill_frame(1'b0);
               send_frame(0, $urandom_range(2, 15));
            end
            19: begin
               random_words();
               fill_frame(1'b0);
               frame_buf[16] = HDR_FIRST;
               send_frame(0, 16);
               random_words();
               fill_frame(1'b0);
               send_frame(1, 16);
            end
            default: begin
               random_words();
               fill_frame(1'b0);
               send_frame(0, 16);
            end
         endcase
      end
      drain_readings();
   endtask

   // Reset, directed cases, pressure, random stream, then the verdict.
   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = 8'd0;
      req_idle          = 1'b0;
      rsp_idle          = 1'b0;
      rsp_hold_cycles   = 0;
      error_count       = 0;
      bytes_sent        = 0;
      frames_sent       = 0;
      corrupt_frames    = 0;
      readings_checked  = 0;
      track_pos         = POS_HUNT;
      last_byte         = 8'd0;
      frame_sum         = 8'd0;
      heading_ref       = 16'd0;
      heading_ref_valid = 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         payload[i] = 8'd0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_frame();
      test_field_extremes();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      test_bad_checksum();
      test_header_in_frame();
      test_header_after_frame();
      test_backpressure();
      req_idle = 1'b1;
      test_random_stream();

      repeat (10) @(posedge clock);
      $display("Run covered %0d bytes and %0d frames, %0d of them with a bad checksum.",
               bytes_sent, frames_sent, corrupt_frames);
      $display("Readings compared: %0d, mismatches: %0d.", readings_checked, error_count);
      if (error_count == 0 && pending_readings.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
